### hdl/drc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty rectangle coalescer package
// Shared widths, opcodes and payload types of the coalescer.
// ----------------------------------------------------------------------------
package drc_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int AREA_W     = 2 * DIFF_W;
  localparam int CMP_W      = AREA_W + 2;
  localparam int CNT_W      = 6;
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(20);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic {
    OP_RECT  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef struct packed {
    op_t    opcode;
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } in_t;

  typedef struct packed {
    coord_t out_left;
    coord_t out_top;
    coord_t out_right;
    coord_t out_bottom;
    logic   last;
  } out_t;

  typedef struct packed {
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
  } push_t;

endpackage

### hdl/dirty_rect_coalescer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty rectangle coalescer
// Merges damaged rectangles into an open bounding box and emits update boxes.
// ----------------------------------------------------------------------------
// Each input transfer is registered, then handled by the combinational merge
// logic, which writes zero, one or two boxes into a two-entry result queue
// that drives the output channel. An item that emits at most one box can be
// taken every cycle while out_ready is high; one that emits two boxes holds
// back the next item until one of its boxes has left, because the single
// result port drains the queue one box per cycle. The merge limit register
// is written by cfg_we and takes effect on the next item.
module dirty_rect_coalescer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [drc_pkg::CNT_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  drc_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output drc_pkg::out_t              out_data
);
  import drc_pkg::*;

  logic   in_valid_r, in_valid_nxt;
  in_t    in_data_r;
  logic   space_ok;
  logic   take;
  push_t  push;

  assign take     = in_valid_r && space_ok;
  assign in_ready = !in_valid_r || space_ok;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (take) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  drc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .take     (take),
    .item     (in_data_r),
    .push     (push)
  );

  drc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hdl/drc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty rectangle coalescer core
// Holds the open box, the saved box and its area, the merge count and the
// limit register, and works out the boxes that one item emits.
// ----------------------------------------------------------------------------
module drc_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [drc_pkg::CNT_W-1:0]  cfg_data,
  input  logic                       take,
  input  drc_pkg::in_t               item,
  output drc_pkg::push_t             push
);
  import drc_pkg::*;

  coord_t grow_left_r, grow_top_r, grow_right_r, grow_bottom_r;
  coord_t grow_left_nxt, grow_top_nxt, grow_right_nxt, grow_bottom_nxt;
  coord_t saved_left_r, saved_top_r, saved_right_r, saved_bottom_r;
  coord_t saved_left_nxt, saved_top_nxt, saved_right_nxt, saved_bottom_nxt;
  logic signed [AREA_W-1:0] saved_area_r, saved_area_nxt;
  logic                     box_open_r, box_open_nxt;
  logic [CNT_W-1:0]         merge_count_r, merge_count_nxt;
  logic [CNT_W-1:0]         merge_limit_r;

  coord_t base_l, base_t, base_r, base_b;
  coord_t sav_l, sav_t, sav_r, sav_b;
  coord_t gl, gt, gr, gb;
  logic signed [DIFF_W-1:0] wd, ht;
  logic signed [AREA_W-1:0] na, oa;
  logic signed [CMP_W-1:0]  na_x, oa4;
  logic                     less;
  logic [CNT_W:0]           cnt1;
  logic                     over;

  assign base_l = box_open_r ? grow_left_r   : item.left;
  assign base_t = box_open_r ? grow_top_r    : item.top;
  assign base_r = box_open_r ? grow_right_r  : item.right;
  assign base_b = box_open_r ? grow_bottom_r : item.bottom;
  assign sav_l  = box_open_r ? saved_left_r   : item.left;
  assign sav_t  = box_open_r ? saved_top_r    : item.top;
  assign sav_r  = box_open_r ? saved_right_r  : item.right;
  assign sav_b  = box_open_r ? saved_bottom_r : item.bottom;

  assign gl = (item.left   < base_l) ? item.left   : base_l;
  assign gt = (item.top    < base_t) ? item.top    : base_t;
  assign gr = (item.right  > base_r) ? item.right  : base_r;
  assign gb = (item.bottom > base_b) ? item.bottom : base_b;

  assign wd   = DIFF_W'(gr) - DIFF_W'(gl);
  assign ht   = DIFF_W'(gb) - DIFF_W'(gt);
  assign na   = AREA_W'(wd) * AREA_W'(ht);
  assign oa   = box_open_r ? saved_area_r : na;
  assign na_x = CMP_W'(na);
  assign oa4  = $signed({oa, 2'b00});
  assign less = na_x < oa4;

  assign cnt1 = less ? ({1'b0, merge_count_r} + (CNT_W+1)'(1)) : (CNT_W+1)'(1);
  assign over = cnt1 > {1'b0, merge_limit_r};

  always_comb begin
    grow_left_nxt    = grow_left_r;
    grow_top_nxt     = grow_top_r;
    grow_right_nxt   = grow_right_r;
    grow_bottom_nxt  = grow_bottom_r;
    saved_left_nxt   = saved_left_r;
    saved_top_nxt    = saved_top_r;
    saved_right_nxt  = saved_right_r;
    saved_bottom_nxt = saved_bottom_r;
    saved_area_nxt   = saved_area_r;
    box_open_nxt     = box_open_r;
    merge_count_nxt  = merge_count_r;
    push.n  = 2'd0;
    push.r0 = '{out_left: grow_left_r, out_top: grow_top_r, out_right: grow_right_r,
                out_bottom: grow_bottom_r, last: 1'b1};
    push.r1 = '{out_left: item.left, out_top: item.top, out_right: item.right,
                out_bottom: item.bottom, last: 1'b1};
    if (take) begin
      if (item.opcode == OP_FLUSH) begin
        merge_count_nxt = '0;
        box_open_nxt    = 1'b0;
        if (box_open_r) begin
          push.n = 2'd1;
        end
      end else begin
        grow_left_nxt   = gl;
        grow_top_nxt    = gt;
        grow_right_nxt  = gr;
        grow_bottom_nxt = gb;
        if (less) begin
          saved_left_nxt   = gl;
          saved_top_nxt    = gt;
          saved_right_nxt  = gr;
          saved_bottom_nxt = gb;
          saved_area_nxt   = na;
          if (over) begin
            merge_count_nxt = '0;
            box_open_nxt    = 1'b0;
            push.n  = 2'd1;
            push.r0 = '{out_left: gl, out_top: gt, out_right: gr, out_bottom: gb,
                        last: 1'b1};
          end else begin
            merge_count_nxt = cnt1[CNT_W-1:0];
            box_open_nxt    = 1'b1;
          end
        end else begin
          box_open_nxt    = 1'b0;
          merge_count_nxt = over ? '0 : cnt1[CNT_W-1:0];
          push.n  = 2'd2;
          push.r0 = '{out_left: sav_l, out_top: sav_t, out_right: sav_r, out_bottom: sav_b,
                      last: 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grow_left_r    <= '0;
      grow_top_r     <= '0;
      grow_right_r   <= '0;
      grow_bottom_r  <= '0;
      saved_left_r   <= '0;
      saved_top_r    <= '0;
      saved_right_r  <= '0;
      saved_bottom_r <= '0;
      saved_area_r   <= '0;
      box_open_r     <= 1'b0;
      merge_count_r  <= '0;
      merge_limit_r  <= LIMIT_RESET;
    end else begin
      grow_left_r    <= grow_left_nxt;
      grow_top_r     <= grow_top_nxt;
      grow_right_r   <= grow_right_nxt;
      grow_bottom_r  <= grow_bottom_nxt;
      saved_left_r   <= saved_left_nxt;
      saved_top_r    <= saved_top_nxt;
      saved_right_r  <= saved_right_nxt;
      saved_bottom_r <= saved_bottom_nxt;
      saved_area_r   <= saved_area_nxt;
      box_open_r     <= box_open_nxt;
      merge_count_r  <= merge_count_nxt;
      if (cfg_we) begin
        merge_limit_r <= cfg_data;
      end
    end
  end

endmodule

### hdl/drc_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty rectangle coalescer result queue
// Two-entry queue whose head is the output register of the result channel.
// ----------------------------------------------------------------------------
module drc_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  drc_pkg::push_t  push,
  output logic            space_ok,
  output logic            out_valid,
  input  logic            out_ready,
  output drc_pkg::out_t   out_data
);
  import drc_pkg::*;

  out_t       q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0] count_r, count_nxt, cnt_after;
  logic       pop;

  assign out_valid = count_r != 2'd0;
  assign out_data  = q0_r;
  assign pop       = out_valid && out_ready;
  assign space_ok  = (count_r == 2'd0) || ((count_r == 2'd1) && out_ready);
  assign cnt_after = count_r - {1'b0, pop};

  always_comb begin
    q0_nxt    = q0_r;
    q1_nxt    = q1_r;
    count_nxt = cnt_after + push.n;
    case (cnt_after)
      2'd0: begin
        q0_nxt = push.r0;
        q1_nxt = push.r1;
      end
      2'd1: begin
        q0_nxt = pop ? q1_r : q0_r;
        q1_nxt = push.r0;
      end
      default: begin
        q0_nxt = q0_r;
        q1_nxt = q1_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("result queue holds more than two entries");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> (3'(cnt_after) + 3'(push.n)) <= 3'd2)
    else $error("results pushed into a full queue");

  a_pair_kept: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == 2'd2 && !q0_r.last |-> q1_r.last)
    else $error("first box of a pair is not followed by the last box");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty rectangle coalescer testbench
// Sends directed rectangles and flushes, then clustered random rectangles with
// noise, under several merge limits. Every emitted update box is predicted and
// each result transfer is compared field by field, with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb_top;
  import drc_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int CHUNK_ITEMS   = 50;
  localparam int PHASE_CHUNKS  = 3;
  localparam int SETTLE_CYCLES = 8;
  localparam int PLAN_SIZE     = 8;
  localparam int RANDOM_LIMIT  = -1;
  localparam int MAX_PRINTS    = 100;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_data  = LIMIT_RESET;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_t              in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;

  in_t  pending_rects [$];
  out_t expected_boxes [$];

  // Predicted state of the coalescer.
  out_t grow_box      = '0;
  out_t saved_box     = '0;
  logic box_open_m    = 1'b0;
  int   merge_count_m = 0;
  int   merge_limit_m = int'(LIMIT_RESET);

  out_t want_box;
  bit   in_xfer       = 1'b0;
  bit   out_xfer      = 1'b0;
  int   send_idle     = 0;
  int   take_idle     = 0;
  int   take_draw     = 0;
  bit   send_burst    = 1'b0;
  bit   take_burst    = 1'b0;
  int   cl_x, cl_y, cl_w, cl_h;
  int   cl_items      = 0;
  int   cycles        = 0;
  int   errors        = 0;
  int   items_sent    = 0;
  int   boxes_checked = 0;

  int limit_plan [0:PLAN_SIZE-1] = '{0, 1, 63, 62, RANDOM_LIMIT, 2, RANDOM_LIMIT,
                                     int'(LIMIT_RESET)};

  int directed_set [0:15][0:4] = '{
    '{OP_RECT,       0,      0,     10,     10},
    '{OP_RECT,       5,      5,     12,     12},
    '{OP_RECT,     100,    100,    110,    110},
    '{OP_FLUSH,     -1,     -1,     -1,     -1},
    '{OP_RECT,  -32768, -32768,  32767,  32767},
    '{OP_RECT,   32767,  32767, -32768, -32768},
    '{OP_FLUSH,      0,      0,      0,      0},
    '{OP_RECT,       5,      5,      5,      5},
    '{OP_RECT,      10,     10,      0,      0},
    '{OP_RECT,      10,      0,      0,     10},
    '{OP_RECT,       0,      0,      1,      1},
    '{OP_FLUSH,  21845, -21846,  21845, -21846},
    '{OP_RECT,  -32768,      0, -32767,      1},
    '{OP_RECT,   32766,     -1,  32767,      0},
    '{OP_RECT,       3,      3,      9,      9},
    '{OP_FLUSH,      7,      7,      7,      7}
  };

  dirty_rect_coalescer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic in_t make_item(op_t op, int l, int t, int r, int b);
    in_t item;
    item.opcode = op;
    item.left   = coord_t'(l);
    item.top    = coord_t'(t);
    item.right  = coord_t'(r);
    item.bottom = coord_t'(b);
    return item;
  endfunction

  function automatic longint box_area(out_t box);
    return (longint'(box.out_right) - longint'(box.out_left)) *
           (longint'(box.out_bottom) - longint'(box.out_top));
  endfunction

  function automatic void predict_update_boxes(in_t item);
    out_t made [0:1];
    out_t rect;
    int   n;
    n = 0;
    rect = '0;
    rect.out_left   = item.left;
    rect.out_top    = item.top;
    rect.out_right  = item.right;
    rect.out_bottom = item.bottom;
    if (item.opcode == OP_FLUSH) begin
      if (box_open_m) begin
        made[n] = grow_box;
        n++;
        box_open_m = 1'b0;
      end
      merge_count_m = 0;
    end else begin
      if (!box_open_m) begin
        grow_box   = rect;
        saved_box  = rect;
        box_open_m = 1'b1;
      end
      if (rect.out_left < grow_box.out_left) grow_box.out_left = rect.out_left;
      if (rect.out_top < grow_box.out_top) grow_box.out_top = rect.out_top;
      if (rect.out_right > grow_box.out_right) grow_box.out_right = rect.out_right;
      if (rect.out_bottom > grow_box.out_bottom) grow_box.out_bottom = rect.out_bottom;
      if (box_area(grow_box) < 4 * box_area(saved_box)) begin
        saved_box = grow_box;
      end else begin
        made[0]       = saved_box;
        made[1]       = rect;
        n             = 2;
        box_open_m    = 1'b0;
        merge_count_m = 0;
      end
      merge_count_m++;
      if (merge_count_m > merge_limit_m) begin
        merge_count_m = 0;
        if (box_open_m) begin
          made[n] = grow_box;
          n++;
          box_open_m = 1'b0;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      made[i].last = (i == n - 1);
      expected_boxes.push_back(made[i]);
    end
  endfunction

  // Most rectangles fall inside a cluster region so that boxes stay open and
  // keep merging; the rest are raw bit patterns, corner values and flushes.
  function automatic in_t random_item();
    int   corner [0:3] = '{-32768, -1, 0, 32767};
    int   pick, l, t, r, b;
    op_t  op;
    if (cl_items == 0) begin
      cl_x     = int'($urandom_range(0, 65535)) - 32768;
      cl_y     = int'($urandom_range(0, 65535)) - 32768;
      cl_w     = ($urandom_range(0, 3) == 0) ? int'($urandom_range(2, 8000))
                                              : int'($urandom_range(2, 64));
      cl_h     = ($urandom_range(0, 3) == 0) ? int'($urandom_range(2, 8000))
                                              : int'($urandom_range(2, 64));
      cl_items = $urandom_range(3, 80);
      pick     = ($urandom_range(0, 1) == 1) ? 99 : int'($urandom_range(0, 98));
    end else begin
      pick = $urandom_range(0, 99);
    end
    cl_items--;
    op = OP_RECT;
    l  = $urandom;
    t  = $urandom;
    r  = $urandom;
    b  = $urandom;
    if (pick < 65) begin
      l = cl_x + int'($urandom_range(0, cl_w / 4));
      t = cl_y + int'($urandom_range(0, cl_h / 4));
      r = cl_x + cl_w - int'($urandom_range(0, cl_w / 4));
      b = cl_y + cl_h - int'($urandom_range(0, cl_h / 4));
    end else if (pick < 75) begin
      l = cl_x + int'($urandom_range(0, cl_w));
      t = cl_y + int'($urandom_range(0, cl_h));
      r = l + int'($urandom_range(0, cl_w / 2));
      b = t + int'($urandom_range(0, cl_h / 2));
    end else if (pick < 85) begin
      op = op_t'($urandom_range(0, 1));
    end else if (pick < 93) begin
      l = corner[$urandom_range(0, 3)];
      t = corner[$urandom_range(0, 3)];
      r = corner[$urandom_range(0, 3)];
      b = corner[$urandom_range(0, 3)];
    end else begin
      op = OP_FLUSH;
    end
    return make_item(op, l, t, r, b);
  endfunction

  function automatic int draw_idle(bit burst);
    return burst ? 0 : int'($urandom_range(0, 12));
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic wait_drained();
    while (pending_rects.size() != 0 || in_valid || expected_boxes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (send_idle > 0) begin
        in_valid  <= 1'b0;
        send_idle <= send_idle - 1;
      end else if (pending_rects.size() > 0) begin
        in_data   <= pending_rects.pop_front();
        in_valid  <= 1'b1;
        send_idle <= draw_idle(send_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_xfer) begin
      take_draw = draw_idle(take_burst);
      take_idle <= (take_draw > 0) ? take_draw - 1 : 0;
      out_ready <= (take_draw == 0);
    end else if (take_idle > 0) begin
      take_idle <= take_idle - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: tracks the register, checks results and predicts new ones.
  always @(posedge clk) begin
    in_xfer  <= rst_n && in_valid && in_ready;
    out_xfer <= rst_n && out_valid && out_ready;
    if (rst_n) begin
      if (cfg_we) merge_limit_m = int'(cfg_data);
      if (out_valid && out_ready) begin
        if (expected_boxes.size() == 0) begin
          report_mismatch($sformatf("box %0d %0d %0d %0d with nothing expected",
                                    out_data.out_left, out_data.out_top,
                                    out_data.out_right, out_data.out_bottom));
        end else begin
          want_box = expected_boxes.pop_front();
          boxes_checked++;
          if (out_data.out_left !== want_box.out_left)
            report_mismatch($sformatf("out_left %0d, expected %0d",
                                      out_data.out_left, want_box.out_left));
          if (out_data.out_top !== want_box.out_top)
            report_mismatch($sformatf("out_top %0d, expected %0d",
                                      out_data.out_top, want_box.out_top));
          if (out_data.out_right !== want_box.out_right)
            report_mismatch($sformatf("out_right %0d, expected %0d",
                                      out_data.out_right, want_box.out_right));
          if (out_data.out_bottom !== want_box.out_bottom)
            report_mismatch($sformatf("out_bottom %0d, expected %0d",
                                      out_data.out_bottom, want_box.out_bottom));
          if (out_data.last !== want_box.last)
            report_mismatch($sformatf("last %0b, expected %0b",
                                      out_data.last, want_box.last));
        end
      end
      if (in_valid && in_ready) begin
        items_sent++;
        predict_update_boxes(in_data);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    int setting;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 16; i++)
      pending_rects.push_back(make_item(op_t'(directed_set[i][0]), directed_set[i][1],
                                        directed_set[i][2], directed_set[i][3],
                                        directed_set[i][4]));
    wait_drained();
    for (int p = 0; p <= PLAN_SIZE; p++) begin
      if (p > 0) begin
        setting = (limit_plan[p-1] == RANDOM_LIMIT) ? int'($urandom_range(1, 62))
                                                    : limit_plan[p-1];
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= CNT_W'(setting);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
      end
      for (int c = 0; c < PHASE_CHUNKS; c++) begin
        send_burst = ($urandom_range(0, 3) == 0);
        take_burst = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < CHUNK_ITEMS; k++) pending_rects.push_back(random_item());
        while (pending_rects.size() != 0) @(posedge clk);
      end
      wait_drained();
    end
    $display("tb_top summary: %0d rectangles and flushes over %0d merge limit settings,",
             items_sent, PLAN_SIZE + 1);
    $display("tb_top summary: %0d update boxes compared, %0d mismatches",
             boxes_checked, errors);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
